// ----- rtl/mpf_pkg.sv -----
`timescale 1ns / 1ps
// shared types, character codes and lookup tables of the integer printf formatter
// no dependencies

package mpf_pkg;

    // bit width of the character count and position of one input word
    localparam int LEN_W   = 5;
    localparam int ERR_LEN = 5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [7:0] ERR_CHARS [ERR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4f, 8'h52};

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [31:0] arg_word;
    } fmt_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } fmt_out_t;

    // what an accepted word asks for
    typedef enum logic [1:0] {
        CL_NONE,
        CL_TEXT,
        CL_DEC,
        CL_HEX
    } in_class_t;

    typedef enum logic [1:0] {
        EK_CHAR,
        EK_ERROR,
        EK_NUMBER
    } emit_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIZE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic dabble;
        logic size;
        logic emit;
    } mpf_cmd_t;

    typedef struct packed {
        in_class_t in_class;
        logic      conv_last;
        logic      out_free;
        logic      emit_last;
    } mpf_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] digit);
        return HEX_CHARS[digit];
    endfunction

    function automatic logic [7:0] err_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = ERR_CHARS[0];
            3'd1:    ch = ERR_CHARS[1];
            3'd2:    ch = ERR_CHARS[2];
            3'd3:    ch = ERR_CHARS[3];
            3'd4:    ch = ERR_CHARS[4];
            default: ch = ERR_CHARS[0];
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/mpf_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer of the printf formatter: accept, convert, size and emit steps
// depends on mpf_pkg

module mpf_ctrl import mpf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mpf_status_t status,
    output mpf_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    case (status.in_class)
                        CL_TEXT: state_next = ST_EMIT;
                        CL_DEC:  state_next = ST_CONVERT;
                        CL_HEX:  state_next = ST_SIZE;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONVERT: begin
                cmd.dabble = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mpf_datapath.sv -----
`timescale 1ns / 1ps
// datapath of the printf formatter: specifier state, binary to bcd shifter,
// digit store, padding arithmetic and the output register; depends on mpf_pkg

module mpf_datapath import mpf_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  fmt_in_t     in_word,
    input  mpf_cmd_t    cmd,
    output mpf_status_t status,
    input  logic        m_ready,
    output logic        m_valid,
    output fmt_out_t    m_payload
);

    localparam int VAL_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam bit SIGN_OK   = (WORD_BITS <= 32);
    localparam int DIG_SLOTS = (VAL_BITS * 30103 + 99999) / 100000;
    localparam int HEX_SLOTS = (VAL_BITS + 3) / 4;
    localparam int HEX_BITS  = HEX_SLOTS * 4;
    localparam int DIG_IDX_W = $clog2(DIG_SLOTS);
    localparam int CNT_W     = $clog2(DIG_SLOTS + 1);
    localparam int BIT_W     = $clog2(VAL_BITS);

    // specifier state
    logic                 in_spec_reg;
    logic [7:0]           fw_reg;
    logic                 zero_fill_reg;

    // conversion and emission
    emit_kind_t           kind_reg;
    logic [7:0]           char_reg;
    logic                 sign_reg;
    logic [VAL_BITS-1:0]  bin_reg;
    logic [BIT_W-1:0]     bit_cnt_reg;
    logic [3:0]           digit_reg  [DIG_SLOTS];
    logic [3:0]           digit_next [DIG_SLOTS];
    logic [3:0]           pad_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     pos_reg;
    logic                 m_valid_reg;
    fmt_out_t             out_reg;

    // accept decode
    logic [7:0]           ch;
    logic [VAL_BITS-1:0]  arg_val;
    logic [VAL_BITS-1:0]  mag_sel;
    logic [HEX_BITS-1:0]  hex_val;
    logic                 is_digit;
    logic                 neg;
    logic [11:0]          fw_wide;
    logic [7:0]           fw_sat;
    in_class_t            cls;
    emit_kind_t           kind_n;
    logic [7:0]           char_n;
    logic                 dec_sign;

    // sizing and emission
    logic [CNT_W-1:0]     ndig;
    logic [8:0]           pad_diff;
    logic [3:0]           pad_n;
    logic [LEN_W-1:0]     sign_end;
    logic [LEN_W-1:0]     pad_end;
    logic [LEN_W-1:0]     didx;
    logic [3:0]           adj        [DIG_SLOTS];
    fmt_out_t             emit_word;

    assign ch       = in_word.fmt_char;
    assign arg_val  = in_word.arg_word[VAL_BITS-1:0];
    assign hex_val  = HEX_BITS'(arg_val);
    assign is_digit = (ch >= CH_0) && (ch <= CH_9);
    assign neg      = SIGN_OK && arg_val[VAL_BITS-1];
    assign fw_wide  = 12'({fw_reg, 3'b000}) + 12'({fw_reg, 1'b0}) + 12'(ch - CH_0);
    assign fw_sat   = (fw_wide > 12'd255) ? 8'd255 : fw_wide[7:0];
    assign mag_sel  = dec_sign ? (VAL_BITS'(0) - arg_val) : arg_val;

    always_comb begin
        cls      = CL_NONE;
        kind_n   = EK_NUMBER;
        char_n   = ch;
        dec_sign = 1'b0;
        if (!in_spec_reg) begin
            if (ch != CH_PCT && ch != CH_NUL) begin
                cls    = CL_TEXT;
                kind_n = EK_CHAR;
            end
        end else if (!is_digit) begin
            case (ch)
                CH_C: begin
                    cls    = CL_TEXT;
                    kind_n = EK_CHAR;
                    char_n = in_word.arg_word[7:0];
                end
                CH_D: begin
                    cls      = CL_DEC;
                    dec_sign = neg;
                end
                CH_U: begin
                    cls = CL_DEC;
                end
                CH_X, CH_UX: begin
                    cls = CL_HEX;
                end
                CH_PCT: begin
                    cls    = CL_TEXT;
                    kind_n = EK_CHAR;
                    char_n = CH_PCT;
                end
                default: begin
                    cls    = CL_TEXT;
                    kind_n = EK_ERROR;
                end
            endcase
        end
    end

    // add-3 correction ahead of each shift of the bcd register
    always_comb begin
        for (int i = 0; i < DIG_SLOTS; i++) begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < DIG_SLOTS; i++) begin
            digit_next[i] = digit_reg[i];
            if (cmd.accept) begin
                if (cls == CL_HEX && i < HEX_SLOTS) begin
                    digit_next[i] = hex_val[i*4 +: 4];
                end else begin
                    digit_next[i] = 4'd0;
                end
            end else if (cmd.dabble) begin
                if (i == 0) begin
                    digit_next[i] = {adj[i][2:0], bin_reg[VAL_BITS-1]};
                end else begin
                    digit_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
            end
        end
    end

    // digit count: index of the highest nonzero digit plus one, at least one
    always_comb begin
        ndig = CNT_W'(1);
        for (int i = 1; i < DIG_SLOTS; i++) begin
            if (digit_reg[i] != 4'd0) begin
                ndig = CNT_W'(i + 1);
            end
        end
    end

    assign pad_diff = {1'b0, fw_reg} - 9'(ndig);
    assign pad_n    = (pad_diff >= 9'd1 && pad_diff <= 9'd14) ? pad_diff[3:0] : 4'd0;

    assign sign_end = LEN_W'(sign_reg);
    assign pad_end  = sign_end + LEN_W'(pad_reg);
    assign didx     = len_reg - LEN_W'(1) - pos_reg;

    always_comb begin
        emit_word.last = (pos_reg == len_reg - LEN_W'(1));
        case (kind_reg)
            EK_CHAR: begin
                emit_word.out_char = char_reg;
            end
            EK_ERROR: begin
                emit_word.out_char = err_char(pos_reg[2:0]);
            end
            EK_NUMBER: begin
                if (pos_reg < sign_end) begin
                    emit_word.out_char = CH_MINUS;
                end else if (pos_reg < pad_end) begin
                    emit_word.out_char = zero_fill_reg ? CH_0 : CH_SPACE;
                end else begin
                    emit_word.out_char = hex_char(digit_reg[didx[DIG_IDX_W-1:0]]);
                end
            end
            default: begin
                emit_word.out_char = char_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_spec_reg   <= 1'b0;
            fw_reg        <= 8'd0;
            zero_fill_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (!in_spec_reg) begin
                    if (ch == CH_PCT) begin
                        in_spec_reg   <= 1'b1;
                        fw_reg        <= 8'd0;
                        zero_fill_reg <= 1'b0;
                    end
                end else if (is_digit) begin
                    if (ch == CH_0 && fw_reg == 8'd0) begin
                        zero_fill_reg <= 1'b1;
                    end
                    fw_reg <= fw_sat;
                end else begin
                    in_spec_reg <= 1'b0;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DIG_SLOTS; i++) begin
            digit_reg[i] <= digit_next[i];
        end
        if (cmd.accept) begin
            kind_reg    <= kind_n;
            char_reg    <= char_n;
            sign_reg    <= dec_sign;
            bin_reg     <= mag_sel;
            bit_cnt_reg <= '0;
            pad_reg     <= 4'd0;
            pos_reg     <= '0;
            len_reg     <= (kind_n == EK_ERROR) ? LEN_W'(ERR_LEN) : LEN_W'(1);
        end
        if (cmd.dabble) begin
            bin_reg     <= {bin_reg[VAL_BITS-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
        end
        if (cmd.size) begin
            pad_reg <= pad_n;
            len_reg <= LEN_W'(sign_reg) + LEN_W'(pad_n) + LEN_W'(ndig);
            pos_reg <= '0;
        end
        if (cmd.emit) begin
            out_reg <= emit_word;
            pos_reg <= pos_reg + LEN_W'(1);
        end
    end

    assign status.in_class  = cls;
    assign status.conv_last = (bit_cnt_reg == BIT_W'(VAL_BITS - 1));
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.emit_last = emit_word.last;

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

// ----- rtl/mini_printf_formatter.sv -----
`timescale 1ns / 1ps
// Streaming integer printf formatter. One format character is taken per word on the
// s_ channel, with a 32-bit argument that only a completing conversion uses; the text
// comes out one character per word on the m_ channel, the final character of each
// input flagged by last. Supported: literals, %c, %d, %u, %x, %X, %%, field width with
// optional zero fill; anything else (including %s) prints ERROR. A word that produces
// text is accepted, then one character leaves per cycle while m_ready is high. %x
// first passes through a sizing step; %d and %u first run the shift-and-add-3 binary
// to decimal converter over the low min(WORD_BITS,32) bits of the argument, then the
// sizing step. A new word is taken as soon as the previous one's last character sits
// in the output register. Depends on mpf_pkg, mpf_ctrl and mpf_datapath.

module mini_printf_formatter import mpf_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fmt_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output fmt_out_t m_payload
);

    mpf_cmd_t    cmd;
    mpf_status_t status;

    mpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mpf_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_word   (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule
